// ===== hdl/sorted_index_equi_join_defines.svh =====
// Assertion macros shared by the checker.
`ifndef SORTED_INDEX_EQUI_JOIN_DEFINES_SVH
`define SORTED_INDEX_EQUI_JOIN_DEFINES_SVH

// Implication checked on every edge outside reset.
`define SIJ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SIJ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sij_pkg.sv =====
`default_nettype none
package sij_pkg;
  localparam int TableDepth = 64;
  localparam int FieldBits  = 32;
  localparam int IdxBits    = $clog2(TableDepth);
  localparam int CntBits    = $clog2(TableDepth + 1);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PROBE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_MATCH   = 3'd0,
    ST_NOMATCH = 3'd1,
    ST_LOADED  = 3'd2,
    ST_FULL    = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] tuple_key;
    logic [31:0] tuple_val;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] left_key;
    logic [31:0] left_val;
    logic [31:0] right_key;
    logic [31:0] right_val;
    logic        last;
  } out_word_t;

  // One index entry: value, key.
  localparam int EntryBits = 2 * FieldBits;
endpackage
`default_nettype wire

// ===== hdl/sorted_index_equi_join.sv =====
`default_nettype none
// Sorted-index equi-join engine.
// Input channel: a word (opcode, tuple_key, tuple_val) is taken when start is
// high and busy is low. Opcode load inserts a right tuple into an index kept
// sorted by value (equal values stay in load order); probe finds every entry
// with an equal value; clear empties the index; the unused code is ignored.
// Result channel: each result word is shown for one cycle with out_valid high;
// the receiver cannot stall. The final word of an item carries last.
// Sequencing: one index RAM (single write, single registered read) is the shared
// unit. A binary search halves through S_SRCH_RD and S_SRCH_CMP; a load then
// moves entries up via S_SHIFT_RD and S_SHIFT_WR; a probe scans via S_SCAN_RD
// and S_SCAN_CMP. A match is held until another is found; the last goes out
// when the scan stops. Clear and full-table loads answer in the next cycle.
// The next item is taken once busy drops.
// Reset empties the index; entry contents are not cleared and never read
// beyond the fill count.
module sorted_index_equi_join
  import sij_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire in_word_t  in_word,
  output logic           busy,
  output logic           out_valid,
  output out_word_t      out_word
);
  logic                 ram_we;
  logic [IdxBits-1:0]   ram_waddr, ram_raddr;
  logic [EntryBits-1:0] ram_wdata, ram_rdata;

  sij_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_word, .busy, .out_valid, .out_word,
    .ram_we, .ram_waddr, .ram_wdata, .ram_raddr, .ram_rdata
  );

  sij_ram #(.Width(EntryBits), .Depth(TableDepth)) u_index (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );
endmodule
`default_nettype wire

// ===== hdl/sij_ram.sv =====
`default_nettype none
module sij_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/sij_ctrl.sv =====
`default_nettype none
module sij_ctrl
  import sij_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire in_word_t  in_word,
  output logic           busy,
  output logic           out_valid,
  output out_word_t      out_word,
  output logic           ram_we,
  output logic [IdxBits-1:0]   ram_waddr,
  output logic [EntryBits-1:0] ram_wdata,
  output logic [IdxBits-1:0]   ram_raddr,
  input  wire logic [EntryBits-1:0] ram_rdata
);
  typedef enum logic [2:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_SHIFT_RD, S_SHIFT_WR, S_SCAN_RD, S_SCAN_CMP
  } state_t;

  state_t              state_r;
  logic [CntBits-1:0]  count_r;
  logic [CntBits-1:0]  lo_r, hi_r, ptr_r;
  logic [1:0]          op_r;
  logic [FieldBits-1:0] key_r, val_r;
  logic                found_r;
  logic [FieldBits-1:0] held_key_r;
  logic [CntBits-1:0]  mid;
  logic [FieldBits-1:0] rd_val, rd_key;
  logic                go_right;

  function automatic out_word_t mk_word(input status_t st,
                                        input logic [FieldBits-1:0] lk,
                                        input logic [FieldBits-1:0] lv,
                                        input logic [FieldBits-1:0] rk,
                                        input logic [FieldBits-1:0] rv,
                                        input logic lst);
    out_word_t w;
    w.status    = st;
    w.left_key  = lk;
    w.left_val  = lv;
    w.right_key = rk;
    w.right_val = rv;
    w.last      = lst;
    return w;
  endfunction

  assign busy = (state_r != S_IDLE);
  assign mid  = lo_r + ((hi_r - lo_r) >> 1);
  assign rd_val = ram_rdata[EntryBits-1:FieldBits];
  assign rd_key = ram_rdata[FieldBits-1:0];
  // Shared comparator: upper bound for load, lower bound for probe.
  assign go_right = (op_r == OP_LOAD) ? (rd_val <= val_r) : (rd_val < val_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_r[IdxBits-1:0];
    ram_wdata = {val_r, key_r};
    ram_raddr = mid[IdxBits-1:0];
    case (state_r)
      S_SHIFT_RD: ram_raddr = ptr_r[IdxBits-1:0] - 1'b1;
      S_SCAN_RD:  ram_raddr = ptr_r[IdxBits-1:0];
      S_SHIFT_WR: begin
        ram_we = 1'b1;
        if (ptr_r != lo_r) ram_wdata = ram_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: if (start) begin
          op_r  <= in_word.opcode;
          key_r <= in_word.tuple_key;
          val_r <= in_word.tuple_val;
          lo_r  <= '0;
          hi_r  <= count_r;
          found_r <= 1'b0;
          case (in_word.opcode)
            OP_LOAD: if (count_r == CntBits'(TableDepth)) begin
              out_word  <= mk_word(ST_FULL, '0, '0, '0, '0, 1'b1);
              out_valid <= 1'b1;
            end else begin
              state_r <= S_SRCH_RD;
            end
            OP_PROBE: state_r <= S_SRCH_RD;
            OP_CLEAR: begin
              count_r   <= '0;
              out_word  <= mk_word(ST_CLEARED, '0, '0, '0, '0, 1'b1);
              out_valid <= 1'b1;
            end
            default: ;
          endcase
        end
        S_SRCH_RD: begin
          if (lo_r == hi_r) begin
            ptr_r <= (op_r == OP_LOAD) ? count_r : lo_r;
            state_r <= (op_r == OP_LOAD) ? S_SHIFT_RD : S_SCAN_RD;
          end else begin
            state_r <= S_SRCH_CMP;
          end
        end
        S_SRCH_CMP: begin
          if (go_right) lo_r <= mid + 1'b1;
          else          hi_r <= mid;
          state_r <= S_SRCH_RD;
        end
        S_SHIFT_RD: state_r <= S_SHIFT_WR;
        S_SHIFT_WR: begin
          if (ptr_r == lo_r) begin
            count_r   <= count_r + 1'b1;
            out_word  <= mk_word(ST_LOADED, '0, '0, '0, '0, 1'b1);
            out_valid <= 1'b1;
            state_r   <= S_IDLE;
          end else begin
            ptr_r <= ptr_r - 1'b1;
            state_r <= S_SHIFT_RD;
          end
        end
        S_SCAN_RD: begin
          if (ptr_r == count_r) begin
            // Table end: the held match goes out as last, or a no-match word.
            if (found_r) begin
              out_word <= mk_word(ST_MATCH, key_r, val_r, held_key_r, val_r, 1'b1);
            end else begin
              out_word <= mk_word(ST_NOMATCH, key_r, val_r, '0, '0, 1'b1);
            end
            out_valid <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          ptr_r <= ptr_r + 1'b1;
          if (rd_val == val_r) begin
            // Another match follows, so the held one is not last.
            if (found_r) begin
              out_word  <= mk_word(ST_MATCH, key_r, val_r, held_key_r, val_r, 1'b0);
              out_valid <= 1'b1;
            end
            found_r    <= 1'b1;
            held_key_r <= rd_key;
            state_r    <= S_SCAN_RD;
          end else begin
            if (found_r) begin
              out_word <= mk_word(ST_MATCH, key_r, val_r, held_key_r, val_r, 1'b1);
            end else begin
              out_word <= mk_word(ST_NOMATCH, key_r, val_r, '0, '0, 1'b1);
            end
            out_valid <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/sij_checker.sv =====
`default_nettype none
`include "sorted_index_equi_join_defines.svh"
module sij_checker
  import sij_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire in_word_t  in_word,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire out_word_t out_word
);
  `SIJ_ASSERT_NEXT(a_clear_ans, clk, rst_n, start && !busy && in_word.opcode == OP_CLEAR, out_valid && out_word.status == ST_CLEARED && out_word.last, "clear not answered")
  `SIJ_ASSERT_IMP(a_match_right, clk, rst_n, out_valid && out_word.status == ST_MATCH, out_word.right_val == out_word.left_val, "match value differs")
  `SIJ_ASSERT_IMP(a_zero_right, clk, rst_n, out_valid && out_word.status != ST_MATCH, out_word.right_key == '0 && out_word.right_val == '0 && out_word.last, "nonmatch word malformed")
  `SIJ_ASSERT_NEXT(a_probe_busy, clk, rst_n, start && !busy && in_word.opcode == OP_PROBE, busy, "probe not busy")
endmodule

bind sorted_index_equi_join sij_checker u_chk (.*);
`default_nettype wire
